/* sv/graph_bridge_finder_assert.svh */
// Assertion macros for the bridge finder checker.
`ifndef GRAPH_BRIDGE_FINDER_ASSERT_SVH
`define GRAPH_BRIDGE_FINDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GBF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("graph_bridge_finder: check failed");

// Next-cycle implication, disabled while reset is held.
`define GBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("graph_bridge_finder: check failed");

`endif

/* sv/gbf_pkg.sv */
`default_nettype none
package gbf_pkg;

    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 5;
    localparam int LIST_DEPTH = 31;
    localparam int GROUP      = 8;

    // Edge held out of the graph during one reachability pass.
    typedef struct packed {
        logic [IDX_W-1:0] cut_u;
        logic [IDX_W-1:0] cut_v;
    } gbf_cut_t;

endpackage
`default_nettype wire

/* sv/gbf_lane.sv */
`default_nettype none
module gbf_lane
    import gbf_pkg::*;
#(
    parameter int MAXV    = 32,
    parameter int LANE_ID = 0
)
(
    input  wire logic [MAXV-1:0] row_bits,
    input  wire logic [MAXV-1:0] col_bits,
    input  wire logic [MAXV-1:0] vmask,
    input  wire logic            active,
    input  wire gbf_cut_t        cut,
    output logic      [MAXV-1:0] contrib
);

    localparam logic [MAXV-1:0] ONE  = {{(MAXV-1){1'b0}}, 1'b1};
    localparam logic [MAXV-1:0] SELF = ONE << LANE_ID;
    localparam logic [IDX_W-1:0] ME  = IDX_W'(LANE_ID);

    logic [MAXV-1:0] sym;
    logic [MAXV-1:0] drop;

    // Symmetric, self-loop free neighbour set of this vertex.
    assign sym = (row_bits | col_bits) & vmask & ~SELF;

    always_comb
    begin
        drop = '0;
        if (cut.cut_u == ME)
        begin
            drop = drop | (ONE << cut.cut_v);
        end
        if (cut.cut_v == ME)
        begin
            drop = drop | (ONE << cut.cut_u);
        end
    end

    assign contrib = active ? (sym & ~drop) : '0;

endmodule
`default_nettype wire

/* sv/gbf_merge.sv */
`default_nettype none
module gbf_merge
    import gbf_pkg::*;
#(
    parameter int MAXV = 32
)
(
    input  wire logic            clk,
    input  wire logic [MAXV-1:0] contrib [MAXV],
    output logic      [MAXV-1:0] merged
);

    localparam int NGROUPS = (MAXV + GROUP - 1) / GROUP;

    logic [MAXV-1:0] group_reg  [NGROUPS];
    logic [MAXV-1:0] group_next [NGROUPS];

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < MAXV)
                begin
                    group_next[g] = group_next[g] | contrib[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_reg[g] <= group_next[g];
        end
    end

    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            merged = merged | group_reg[g];
        end
    end

endmodule
`default_nettype wire

/* sv/graph_bridge_finder.sv */
`default_nettype none
// Bridge finder for an undirected graph of up to MAX_VERTICES vertices. Load the
// adjacency matrix one row per input item, one item a cycle while idle; the row
// with tlast set is stored like any other and then starts the search, and input
// is held off until the last result has been loaded into the output register.
// The search walks every pair u<v; for each edge present it runs a breadth-first
// reachability from u with that edge removed, one lane per vertex expanding the
// whole frontier at once and a registered OR tree merging the lanes. A pass
// stops as soon as v is reached. Results then leave one a cycle while the
// receiver takes them: a header with the bridge count (tlast set alone when
// there are no bridges), then each bridge with its 1-based endpoints in order.
// Rows are read symmetrically (an edge exists if either row names it), and bits
// and rows above vertex_count are ignored. Write vertex_count only while idle.
module graph_bridge_finder
    import gbf_pkg::*;
#(
    parameter int MAX_VERTICES = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: vertex_count
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,
    // input rows
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [5:0] row_index, [37:6] row_bits
    input  wire logic        s_tlast,   // last_row
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [4:0] bridge_count, [10:5] end_low,
                                        // [16:11] end_high
    output logic             m_tuser,   // is_header
    output logic             m_tlast    // last_result
);

    localparam int MAXV = MAX_VERTICES;
    localparam int IW   = $clog2(MAXV);
    localparam int CW   = IDX_W + 1;
    localparam logic [CW-1:0] MAXV_W = CW'(MAXV);
    localparam logic [MAXV-1:0] ONE  = {{(MAXV-1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_BFS_A = 3'd2;
    localparam logic [2:0] ST_BFS_B = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]         state_reg,    state_next;
    logic [5:0]         vcount_reg;
    logic [MAXV-1:0]    adj_reg [MAXV];
    logic [CW-1:0]      u_reg,        u_next;
    logic [CW-1:0]      v_reg,        v_next;
    logic [MAXV-1:0]    reached_reg,  reached_next;
    logic [MAXV-1:0]    frontier_reg, frontier_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [COUNT_W-1:0] emit_reg,     emit_next;
    logic [2*IDX_W-1:0] list_reg [LIST_DEPTH];
    logic               m_tvalid_reg;
    logic [23:0]        m_tdata_reg;
    logic               m_tuser_reg;
    logic               m_tlast_reg;

    // ---------------------------------------------------------------
    // Row capture: widen or trim the 32 row bits to the vertex range.
    // ---------------------------------------------------------------
    logic [5:0]       in_index;
    logic [MAXV+31:0] row_wide;
    logic [MAXV-1:0]  row_val;
    logic             in_fire;
    logic             row_ok;
    logic [IW-1:0]    row_addr;

    assign in_index = s_tdata[5:0];
    assign row_wide = {{MAXV{1'b0}}, s_tdata[37:6]};
    assign row_val  = row_wide[MAXV-1:0];
    assign in_fire  = s_tvalid && s_tready;
    assign row_ok   = (in_index != 6'd0) && ({1'b0, in_index} <= MAXV_W);
    assign row_addr = IW'(in_index - 6'd1);

    always_ff @(posedge clk)
    begin
        if (in_fire && row_ok)
        begin
            adj_reg[row_addr] <= row_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 6'd32;
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    // Vertices in use: zero reads as one, clamp at the array size.
    logic [CW-1:0]   n_eff;
    logic [MAXV-1:0] vmask;

    always_comb
    begin
        if (vcount_reg == 6'd0)
        begin
            n_eff = CW'(1);
        end
        else if ({1'b0, vcount_reg} > MAXV_W)
        begin
            n_eff = MAXV_W;
        end
        else
        begin
            n_eff = {1'b0, vcount_reg};
        end
        for (int j = 0; j < MAXV; j++)
        begin
            vmask[j] = (CW'(j) < n_eff);
        end
    end

    // ---------------------------------------------------------------
    // Lanes: one per vertex, each owns its row and its column.
    // ---------------------------------------------------------------
    logic [MAXV-1:0] col_bits [MAXV];
    logic [MAXV-1:0] contrib  [MAXV];
    logic [MAXV-1:0] merged;
    gbf_cut_t        cut;

    assign cut = '{cut_u: u_reg[IDX_W-1:0], cut_v: v_reg[IDX_W-1:0]};

    for (genvar x = 0; x < MAXV; x++)
    begin : g_lane
        for (genvar j = 0; j < MAXV; j++)
        begin : g_col
            assign col_bits[x][j] = adj_reg[j][x];
        end

        gbf_lane #(
            .MAXV    (MAXV),
            .LANE_ID (x)
        ) u_lane (
            .row_bits (adj_reg[x]),
            .col_bits (col_bits[x]),
            .vmask    (vmask),
            .active   (frontier_reg[x]),
            .cut      (cut),
            .contrib  (contrib[x])
        );
    end

    gbf_merge #(
        .MAXV (MAXV)
    ) u_merge (
        .clk     (clk),
        .contrib (contrib),
        .merged  (merged)
    );

    // ---------------------------------------------------------------
    // Search sequencer.
    // ---------------------------------------------------------------
    logic [IW-1:0]   u_i;
    logic [IW-1:0]   v_i;
    logic            edge_hit;
    logic [MAXV-1:0] level_new;
    logic [MAXV-1:0] level_reached;
    logic            out_free;
    logic            out_load;
    logic            list_we;
    logic [23:0]     load_data;
    logic            load_user;
    logic            load_last;
    logic [2*IDX_W-1:0] list_entry;

    assign u_i      = u_reg[IW-1:0];
    assign v_i      = v_reg[IW-1:0];
    assign edge_hit = (v_reg < n_eff) && (adj_reg[u_i][v_i] || adj_reg[v_i][u_i]);

    assign level_new     = merged & ~reached_reg;
    assign level_reached = reached_reg | level_new;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign list_entry = list_reg[emit_reg - COUNT_W'(1)];

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        reached_next  = reached_reg;
        frontier_next = frontier_reg;
        count_next    = count_reg;
        emit_next     = emit_reg;
        list_we       = 1'b0;
        out_load      = 1'b0;
        load_data     = '0;
        load_user     = 1'b0;
        load_last     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && s_tlast)
                begin
                    u_next     = '0;
                    v_next     = CW'(1);
                    count_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (u_reg + CW'(1) >= n_eff)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else if (v_reg >= n_eff)
                begin
                    u_next = u_reg + CW'(1);
                    v_next = u_reg + CW'(2);
                end
                else if (edge_hit)
                begin
                    reached_next  = ONE << u_i;
                    frontier_next = ONE << u_i;
                    state_next    = ST_BFS_A;
                end
                else
                begin
                    v_next = v_reg + CW'(1);
                end
            end
            ST_BFS_A:
            begin
                state_next = ST_BFS_B;
            end
            ST_BFS_B:
            begin
                reached_next  = level_reached;
                frontier_next = level_new;
                if (level_reached[v_i])
                begin
                    // v still reachable: not a bridge
                    frontier_next = '0;
                    v_next        = v_reg + CW'(1);
                    state_next    = ST_SCAN;
                end
                else if (level_new == '0)
                begin
                    if (count_reg < COUNT_W'(LIST_DEPTH))
                    begin
                        list_we    = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    v_next     = v_reg + CW'(1);
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_BFS_A;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_last = (emit_reg == count_reg);
                    if (emit_reg == '0)
                    begin
                        load_user = 1'b1;
                        load_data = {7'd0, 6'd0, 6'd0, count_reg};
                    end
                    else
                    begin
                        load_data = {7'd0,
                                     list_entry[IDX_W-1:0] + 6'd1,
                                     list_entry[2*IDX_W-1:IDX_W] + 6'd1,
                                     COUNT_W'(0)};
                    end
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            u_reg        <= '0;
            v_reg        <= '0;
            reached_reg  <= '0;
            frontier_reg <= '0;
            count_reg    <= '0;
            emit_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            u_reg        <= u_next;
            v_reg        <= v_next;
            reached_reg  <= reached_next;
            frontier_reg <= frontier_next;
            count_reg    <= count_next;
            emit_reg     <= emit_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Bridge list and output payload hold no reset.
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_reg[count_reg] <= {u_reg[IDX_W-1:0], v_reg[IDX_W-1:0]};
        end
        if (out_load)
        begin
            m_tdata_reg <= load_data;
            m_tuser_reg <= load_user;
            m_tlast_reg <= load_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

/* sv/gbf_checker.sv */
`default_nettype none
`include "graph_bridge_finder_assert.svh"
module gbf_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast
);

    // A stalled result holds.
    `GBF_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // The final row starts the search, which stalls input.
    `GBF_ASSERT_NEXT(a_search_stalls, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready)

    // A header with no bridges closes the run.
    `GBF_ASSERT_NOW(a_empty_header_last, clk, rst_n, m_tvalid && m_tuser && (m_tdata[4:0] == 5'd0), m_tlast)

    // A bridge result never carries a zero lower endpoint or a count.
    `GBF_ASSERT_NOW(a_bridge_fields, clk, rst_n, m_tvalid && !m_tuser, (m_tdata[10:5] != 6'd0) && (m_tdata[4:0] == 5'd0))

endmodule

bind graph_bridge_finder gbf_checker u_gbf_checker (.*);
`default_nettype wire

/* tb/graph_bridge_finder_tb.sv */
`timescale 1ns / 1ps

module graph_bridge_finder_tb;
    import gbf_pkg::*;

    localparam int MAX_V          = 32;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 500;
    // Long enough to outlast the slowest search, so the header backs up.
    localparam int RX_HOLD_CYCLES = 10000;
    // Settle time after the last result before a register write; the block
    // drops back to idle once its final result has been loaded.
    localparam int IDLE_PAUSE     = 4;
    localparam int TAIL_CYCLES    = 50;
    localparam int CYCLE_LIMIT    = 3_000_000;

    // Row indexes that the block never stores.
    localparam logic [IDX_W-1:0] NO_ROW  = 6'd0;
    localparam logic [IDX_W-1:0] TOP_ROW = 6'd63;

    // One result item as it leaves the block.
    typedef struct packed {
        logic               hdr;
        logic [COUNT_W-1:0] count;
        logic [IDX_W-1:0]   end_low;
        logic [IDX_W-1:0]   end_high;
        logic               last;
    } bridge_result_t;

    // One row of the directed table: an optional vertex_count write, then one
    // input item; where typed is set, the header (and at most one bridge) is
    // given here instead of being worked out.
    typedef struct packed {
        logic               wr_cfg;
        logic [5:0]         cfg_val;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        bits;
        logic               last;
        logic               typed;
        logic [COUNT_W-1:0] t_count;
        logic [IDX_W-1:0]   t_low;
        logic [IDX_W-1:0]   t_high;
    } dir_row_t;

    localparam dir_row_t DIRECTED [22] = '{
        // single vertex: self-loop and every bit above it drop out
        '{1'b1, 6'd1,  6'd1,  32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0, 6'd0, 6'd0},
        // edge 1-2 named in one row only
        '{1'b1, 6'd2,  6'd1,  32'h0000_0002, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd2,  32'h0000_0000, 1'b1, 1'b1, 5'd1, 6'd1, 6'd2},
        // vertex_count zero acts as one; row index zero is dropped yet
        // its last flag still starts the search
        '{1'b1, 6'd0,  NO_ROW, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0, 6'd0, 6'd0},
        // triangle: no bridges
        '{1'b1, 6'd3,  6'd1,  32'h0000_0006, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd2,  32'h0000_0005, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd3,  32'h0000_0003, 1'b1, 1'b1, 5'd0, 6'd0, 6'd0},
        // out-of-range rows are not stored; row 3 cleared, edges survive
        // through rows 1 and 2
        '{1'b0, 6'd0,  TOP_ROW, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd33, 32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd3,  32'h0000_0000, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0},
        // path 1-2-3-4 with a row above vertex_count mixed in
        '{1'b1, 6'd4,  6'd1,  32'h0000_0002, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd2,  32'h0000_0004, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd5,  32'h0000_000F, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd3,  32'h0000_0008, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd4,  32'h0000_0000, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0},
        // star on vertex 1, spoke rows partly one-sided, self-loops on 3, 5
        '{1'b1, 6'd5,  6'd1,  32'h0000_001E, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd2,  32'h0000_0001, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd3,  32'h0000_0005, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd4,  32'h0000_0000, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd5,  32'h0000_0010, 1'b1, 1'b0, 5'd0, 6'd0, 6'd0},
        // two isolated vertices: two components, still no bridge
        '{1'b1, 6'd2,  6'd1,  32'h0000_0000, 1'b0, 1'b0, 5'd0, 6'd0, 6'd0},
        '{1'b0, 6'd0,  6'd2,  32'h0000_0000, 1'b1, 1'b1, 5'd0, 6'd0, 6'd0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [5:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // [5:0] row_index, [37:6] row_bits
    logic        s_tlast;   // last_row
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [4:0] bridge_count, [10:5] end_low, [16:11] end_high
    logic        m_tuser;   // is_header
    logic        m_tlast;   // last_result

    // Mirror of the block's stored rows and register, updated on each
    // accepted item and each write.
    logic [31:0]    adj_shadow [MAX_V];
    logic [31:0]    rows_written;
    logic [5:0]     vertex_count_shadow;
    bridge_result_t pending_bridge_results [$];

    int unsigned cycles;
    int          errors;
    int          items_sent;
    bit          tx_calm;
    bit          rx_hold_req;

    graph_bridge_finder #(
        .MAX_VERTICES (MAX_V)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Hard stop: the slowest correct run stays well below this.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Vertices the block actually uses for a given register value.
    function automatic int active_vertices(input logic [5:0] vc);
        if (vc == 6'd0)
            return 1;
        if (vc > MAX_V)
            return MAX_V;
        return int'(vc);
    endfunction

    // Keep most graphs small so searches stay short; a few take zero or a larger
    // value, up to the full size or out of range.
    function automatic logic [5:0] pick_vertex_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 6'($urandom_range(1, 8));
        if (r < 90)
            return 6'($urandom_range(9, 16));
        if (r < 95)
            return 6'd0;
        return 6'($urandom_range(17, 63));
    endfunction

    // Work out the header and bridge items for a search over the shadow rows.
    // The graph is the symmetric closure with self-loops removed; edge u-v is a
    // bridge when v cannot be reached from u once that edge is taken out.
    task automatic predict_bridges();
        int             nv;
        logic [31:0]    sym [MAX_V];
        logic [31:0]    seen;
        logic [31:0]    front;
        logic [31:0]    nxt;
        logic [31:0]    nb;
        bridge_result_t item;
        bridge_result_t found [$];

        nv = active_vertices(vertex_count_shadow);
        for (int i = 0; i < MAX_V; i++)
            sym[i] = '0;
        for (int i = 0; i < nv; i++)
            for (int j = 0; j < nv; j++)
                if (i != j && (adj_shadow[i][j] || adj_shadow[j][i]))
                    sym[i][j] = 1'b1;

        for (int u = 0; u < nv; u++)
        begin
            for (int v = u + 1; v < nv; v++)
            begin
                if (!sym[u][v])
                    continue;
                seen  = 32'd1 << u;
                front = seen;
                // expand one whole frontier at a time
                while (front != '0)
                begin
                    nxt = '0;
                    for (int x = 0; x < nv; x++)
                    begin
                        if (!front[x])
                            continue;
                        nb = sym[x];
                        if (x == u)
                            nb[v] = 1'b0;
                        if (x == v)
                            nb[u] = 1'b0;
                        nxt |= nb;
                    end
                    nxt   &= ~seen;
                    seen  |= nxt;
                    front  = nxt;
                end
                if (!seen[v])
                begin
                    item          = '0;
                    item.end_low  = IDX_W'(u + 1);
                    item.end_high = IDX_W'(v + 1);
                    found.push_back(item);
                end
            end
        end

        item       = '0;
        item.hdr   = 1'b1;
        item.count = COUNT_W'(found.size());
        item.last  = (found.size() == 0);
        pending_bridge_results.push_back(item);
        foreach (found[k])
        begin
            item      = found[k];
            item.last = (k == found.size() - 1);
            pending_bridge_results.push_back(item);
        end
    endtask

    // Offer one item after a random gap and hold it until taken, then update
    // the shadow rows and, on a last row with predict set, queue what the search will report.
    task automatic send_row(input logic [IDX_W-1:0] idx, input logic [31:0] bits,
                            input logic last, input bit predict);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bits, idx};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);

        if (idx >= 1 && idx <= MAX_V)
        begin
            adj_shadow[idx - 1]   = bits;
            rows_written[idx - 1] = 1'b1;
            items_sent++;
        end
        else if (last)
            items_sent++;
        if (last && predict)
            predict_bridges();
    endtask

    // Drop valid and wait until every queued result has left the block.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bridge_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    // Register writes only happen with the block idle.
    task automatic write_vertex_count(input logic [5:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        vertex_count_shadow = value;
    endtask

    // One well-formed frame: every used row once in random order, the last
    // carrying the flag. Rows are one-sided at random, with self-loops and
    // bits above the vertex count sprinkled in, and unused rows between.
    task automatic send_graph(input int n, input bit hold_results);
        logic [31:0]      edges [MAX_V];
        logic [31:0]      rows [MAX_V];
        int               order [$];
        int               style;
        int               dens;
        int               a;
        int               b;
        int               j;
        int               tmp;
        bit               tail_junk;
        bit               is_last;
        logic [IDX_W-1:0] junk;

        for (int i = 0; i < MAX_V; i++)
        begin
            edges[i] = '0;
            rows[i]  = '0;
        end

        style = $urandom_range(0, 3);
        dens  = $urandom_range(5, 60);
        for (int k = 1; k < n; k++)
        begin
            case (style)
                0, 2:
                begin
                    // tree, or forest when some vertices stay unattached
                    if (style == 0 || $urandom_range(0, 9) < 7)
                    begin
                        a = $urandom_range(0, k - 1);
                        edges[k][a] = 1'b1;
                        edges[a][k] = 1'b1;
                    end
                end
                1:
                begin
                    for (int m = 0; m < k; m++)
                        if ($urandom_range(0, 99) < dens)
                        begin
                            edges[k][m] = 1'b1;
                            edges[m][k] = 1'b1;
                        end
                end
                default:
                begin
                    if (dens > 30)
                        for (int m = 0; m < k; m++)
                        begin
                            edges[k][m] = 1'b1;
                            edges[m][k] = 1'b1;
                        end
                end
            endcase
        end
        // a few extra edges close cycles in trees
        if (style == 0 && n > 2)
            repeat ($urandom_range(0, 2))
            begin
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                if (a != b)
                begin
                    edges[a][b] = 1'b1;
                    edges[b][a] = 1'b1;
                end
            end

        for (int u = 0; u < n; u++)
            for (int v = u + 1; v < n; v++)
                if (edges[u][v])
                    case ($urandom_range(0, 2))
                        0:       rows[u][v] = 1'b1;
                        1:       rows[v][u] = 1'b1;
                        default:
                        begin
                            rows[u][v] = 1'b1;
                            rows[v][u] = 1'b1;
                        end
                    endcase
        for (int u = 0; u < n; u++)
        begin
            if ($urandom_range(0, 4) == 0)
                rows[u][u] = 1'b1;
            if (n < MAX_V && $urandom_range(0, 9) < 3)
                rows[u] |= $urandom << n;
        end

        for (int i = 0; i < n; i++)
        begin
            order.push_back(i);
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end

        tail_junk = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       junk = NO_ROW;
                    1:       junk = IDX_W'($urandom_range(MAX_V + 1, int'(TOP_ROW)));
                    default: junk = (n < MAX_V) ? IDX_W'($urandom_range(n + 1, MAX_V))
                                                : NO_ROW;
                endcase
                send_row(junk, $urandom, 1'b0, 1'b1);
            end
            is_last = (k == n - 1) && !tail_junk;
            if (is_last && hold_results)
                rx_hold_req = 1'b1;
            send_row(IDX_W'(order[k] + 1), rows[order[k]], is_last, 1'b1);
        end
        // close the frame with a row that is not stored but still starts it
        if (tail_junk)
        begin
            if (hold_results)
                rx_hold_req = 1'b1;
            junk = $urandom_range(0, 1) ? NO_ROW
                                        : IDX_W'($urandom_range(MAX_V + 1, int'(TOP_ROW)));
            send_row(junk, $urandom, 1'b1, 1'b1);
        end
    endtask

    // Broken frame: a handful of random rows, the search started early only
    // where every used row already holds something.
    task automatic send_broken(input int n);
        int               k;
        logic [IDX_W-1:0] idx;
        logic [31:0]      after;
        logic [31:0]      live;
        logic             last;

        live = (n == MAX_V) ? '1 : ((32'd1 << n) - 32'd1);
        k    = $urandom_range(1, 6);
        for (int i = 0; i < k; i++)
        begin
            idx   = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(1, n))
                                               : IDX_W'($urandom_range(0, int'(TOP_ROW)));
            after = rows_written;
            if (idx >= 1 && idx <= MAX_V)
                after[idx - 1] = 1'b1;
            last = (i == k - 1) && ($urandom_range(0, 9) < 6) && ((after & live) == live);
            send_row(idx, $urandom, last, 1'b1);
        end
    endtask

    // Receiver: random back-pressure with calm stretches, plus one long
    // hold-off on request, counted here so the sender keeps offering meanwhile.
    initial
    begin : receiver
        int gap_left;
        int hold_left;
        bit calm;
        gap_left  = 0;
        hold_left = 0;
        calm      = 1'b0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                calm = !calm;
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                gap_left = calm ? 0 : pick_gap();
            end
        end
    end

    // Compare each result taken with the oldest one waiting.
    always @(posedge clk)
    begin : result_check
        bridge_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bridge_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: hdr=%0b count=%0d low=%0d high=%0d last=%0b",
                         $realtime, m_tuser, m_tdata[4:0], m_tdata[10:5], m_tdata[16:11], m_tlast);
                errors++;
            end
            else
            begin
                want = pending_bridge_results.pop_front();
                if (m_tuser !== want.hdr || m_tlast !== want.last ||
                    m_tdata !== {7'd0, want.end_high, want.end_low, want.count})
                begin
                    $display("%0t: mismatch: expected hdr=%0b count=%0d low=%0d high=%0d last=%0b",
                             $realtime, want.hdr, want.count, want.end_low, want.end_high,
                             want.last);
                    $display("%0t:           actual   hdr=%0b count=%0d low=%0d high=%0d last=%0b pad=%0h",
                             $realtime, m_tuser, m_tdata[4:0], m_tdata[10:5], m_tdata[16:11],
                             m_tlast, m_tdata[23:17]);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        int       frame;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        tx_calm     = 1'b0;
        rx_hold_req = 1'b0;
        cycles      = 0;
        errors      = 0;
        items_sent  = 0;
        rows_written        = '0;
        vertex_count_shadow = 6'd32;
        for (int i = 0; i < MAX_V; i++)
            adj_shadow[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: walk the table; typed rows carry their own answer.
        for (int k = 0; k < $size(DIRECTED); k++)
        begin
            row = DIRECTED[k];
            if (row.wr_cfg)
                write_vertex_count(row.cfg_val);
            send_row(row.idx, row.bits, row.last, !row.typed);
            if (row.typed)
            begin
                pending_bridge_results.push_back('{1'b1, row.t_count, 6'd0, 6'd0,
                                                   row.t_count == 0});
                if (row.t_count != 0)
                    pending_bridge_results.push_back('{1'b0, 5'd0, row.t_low, row.t_high,
                                                       1'b1});
            end
        end

        // Random part. The first frames take the register extremes; the full
        // size frame also fills every row, so later searches read no stale row.
        // The frame after the held one skips the write, so its rows are
        // offered while the results of the held frame back up.
        items_sent = 0;
        frame      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            case (frame)
                0:       write_vertex_count(6'd32);
                1:       write_vertex_count(6'd63);
                2:       write_vertex_count(6'd0);
                default:
                begin
                    if (frame != 5 && $urandom_range(0, 9) < 3)
                        write_vertex_count(pick_vertex_count());
                end
            endcase
            if (frame < 5 || $urandom_range(0, 99) < 85)
                send_graph(active_vertices(vertex_count_shadow), frame == 4);
            else
                send_broken(active_vertices(vertex_count_shadow));
            frame++;
        end

        // Let the last results out, then a short quiet tail.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/gbf_pkg.sv
sv/gbf_lane.sv
sv/gbf_merge.sv
sv/graph_bridge_finder.sv
sv/gbf_checker.sv
tb/graph_bridge_finder_tb.sv
